// ===== rtl/led_matrix_chain_command_engine_core_defines.svh =====
// assertion macros for the led matrix chain command engine
// used by the checker; expects clk and arst_n in scope
`ifndef LED_MATRIX_CHAIN_COMMAND_ENGINE_CORE_DEFINES_SVH
`define LED_MATRIX_CHAIN_COMMAND_ENGINE_CORE_DEFINES_SVH

// checked outside reset only
`define LMCCE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LMCCE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lmcce_pkg.sv =====
// shared types and constants of the led matrix chain command engine
// no dependencies
package lmcce_pkg;

	localparam int MAX_CHAIN       = 8;
	localparam int ROWS_PER_DEVICE = 8;

	localparam logic [7:0] LEFT_BIT       = 8'b1000_0000;
	localparam logic [3:0] REG_INTENSITY  = 4'd10;
	localparam logic [3:0] REG_SCAN_LIMIT = 4'd11;
	localparam logic [3:0] REG_SHUTDOWN   = 4'd12;
	localparam logic [7:0] INTENSITY_MAX  = 8'd15;
	localparam logic [7:0] SCANLIMIT_MAX  = 8'd7;

	typedef enum logic [2:0] {
		MODE_LED,
		MODE_ROW,
		MODE_COLUMN,
		MODE_CLEAR,
		MODE_SHUTDOWN,
		MODE_INTENSITY,
		MODE_SCANLIMIT,
		MODE_RAW
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MERGE,
		ST_SEND
	} state_t;

endpackage

// ===== rtl/led_matrix_chain_command_engine_core.sv =====
// Flow: a command is accepted in idle, then each frame takes a shadow read state, a merge
//   and write state, and chain length words, one per cycle when out_ready is high.
// Frames: 8 per command for column and clear, else 1; the single word sequencer takes no
//   new command until the last word of the current one has gone out.
// Reset: arst_n clears the sequencer, device_count to 1 and all shadow valid bits,
//   so every row byte reads as zero after reset.
module led_matrix_chain_command_engine_core #(
	parameter int MAX_CHAIN = lmcce_pkg::MAX_CHAIN
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	// command channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [2:0]  device,
	input  logic [2:0]  row,
	input  logic [2:0]  column,
	input  logic        flag,
	input  logic [7:0]  value,
	input  logic [3:0]  raw_opcode,
	// serial word channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] word,
	output logic        frame_end,
	output logic        command_end
);

	// shadow geometry follows from the chain length
	localparam int DEPTH = MAX_CHAIN * lmcce_pkg::ROWS_PER_DEVICE;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [3:0] MAX_LEN = 4'(MAX_CHAIN);

	lmcce_pkg::state_t state_q, state_nx;

	// configuration
	logic [3:0] dev_count_q;
	logic [3:0] chain_len;

	// latched command
	lmcce_pkg::mode_t mode_q;
	logic [2:0] dev_q, row_q, col_q;
	logic       flag_q;
	logic [7:0] value_q;
	logic [3:0] rawop_q;

	// sequencer counters and frame contents
	logic [2:0] frame_q;
	logic [2:0] word_k_q;
	logic [3:0] op_q;
	logic [7:0] data_q;

	// shadow memory, valid bits stand in for the zero reset
	logic [7:0]       shadow_mem [DEPTH];
	logic [DEPTH-1:0] shadow_vld_q;
	logic [7:0]       rd_q;
	logic             rd_vld_q;

	// decode
	logic             in_fire, out_fire, cmd_ok;
	logic             multi_frame, frame_last, word_last;
	logic [2:0]       row_sel;
	logic [IDX_W-1:0] shadow_addr;
	logic [7:0]       old_byte, bit_mask, new_data;
	logic [3:0]       new_op, row_op;
	logic             led_on, shadow_we;
	logic [3:0]       word_pos;
	logic             pos_hit;
	logic             do_latch, do_load, do_merge;

	// out of range chain length acts as a full chain
	assign chain_len = (dev_count_q == 4'd0 || dev_count_q > MAX_LEN) ? MAX_LEN : dev_count_q;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	// commands that give no output are dropped at accept
	always_comb begin
		cmd_ok = ({1'b0, device} < chain_len);
		if (lmcce_pkg::mode_t'(mode) == lmcce_pkg::MODE_INTENSITY
				&& value > lmcce_pkg::INTENSITY_MAX)
			cmd_ok = 1'b0;
		if (lmcce_pkg::mode_t'(mode) == lmcce_pkg::MODE_SCANLIMIT
				&& value > lmcce_pkg::SCANLIMIT_MAX)
			cmd_ok = 1'b0;
	end

	// column and clear walk all eight rows, one frame each
	assign multi_frame = (mode_q == lmcce_pkg::MODE_COLUMN) || (mode_q == lmcce_pkg::MODE_CLEAR);
	assign frame_last  = !multi_frame || (frame_q == 3'd7);
	assign row_sel     = multi_frame ? frame_q : row_q;
	assign shadow_addr = IDX_W'({dev_q, row_sel});
	assign row_op      = 4'({1'b0, row_sel} + 4'd1);

	// merge of the fetched row byte with the command
	assign old_byte = rd_vld_q ? rd_q : 8'h00;
	assign bit_mask = lmcce_pkg::LEFT_BIT >> col_q;
	assign led_on   = (mode_q == lmcce_pkg::MODE_LED) ? flag_q : value_q[3'd7 - frame_q];

	always_comb begin
		new_data  = value_q;
		new_op    = row_op;
		shadow_we = 1'b0;
		unique case (mode_q)
			lmcce_pkg::MODE_LED, lmcce_pkg::MODE_COLUMN: begin
				new_data  = led_on ? (old_byte | bit_mask) : (old_byte & ~bit_mask);
				shadow_we = 1'b1;
			end
			lmcce_pkg::MODE_ROW: begin
				shadow_we = 1'b1;
			end
			lmcce_pkg::MODE_CLEAR: begin
				new_data  = 8'h00;
				shadow_we = 1'b1;
			end
			lmcce_pkg::MODE_SHUTDOWN: begin
				// shutdown entered with data zero, left with data one
				new_data = {7'd0, !flag_q};
				new_op   = lmcce_pkg::REG_SHUTDOWN;
			end
			lmcce_pkg::MODE_INTENSITY: new_op = lmcce_pkg::REG_INTENSITY;
			lmcce_pkg::MODE_SCANLIMIT: new_op = lmcce_pkg::REG_SCAN_LIMIT;
			lmcce_pkg::MODE_RAW:       new_op = rawop_q;
		endcase
	end

	// word position in the chain: first word goes to the farthest chip
	assign word_pos  = 4'(chain_len - 4'd1 - {1'b0, word_k_q});
	assign pos_hit   = (word_pos == {1'b0, dev_q});
	assign word_last = ({1'b0, word_k_q} == 4'(chain_len - 4'd1));

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lmcce_pkg::ST_IDLE:  if (in_fire && cmd_ok) state_nx = lmcce_pkg::ST_LOAD;
			lmcce_pkg::ST_LOAD:  state_nx = lmcce_pkg::ST_MERGE;
			lmcce_pkg::ST_MERGE: state_nx = lmcce_pkg::ST_SEND;
			lmcce_pkg::ST_SEND: begin
				if (out_fire && word_last)
					state_nx = frame_last ? lmcce_pkg::ST_IDLE : lmcce_pkg::ST_LOAD;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		do_latch  = 1'b0;
		do_load   = 1'b0;
		do_merge  = 1'b0;
		unique case (state_q)
			lmcce_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				do_latch = in_fire;
			end
			lmcce_pkg::ST_LOAD:  do_load   = 1'b1;
			lmcce_pkg::ST_MERGE: do_merge  = 1'b1;
			lmcce_pkg::ST_SEND:  out_valid = 1'b1;
		endcase
	end

	// payload comes straight from registers held during a stall
	assign word        = pos_hit ? {4'd0, op_q, data_q} : 16'h0000;
	assign frame_end   = word_last;
	assign command_end = word_last && frame_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lmcce_pkg::ST_IDLE;
			dev_count_q  <= 4'd1;
			shadow_vld_q <= '0;
			frame_q      <= 3'd0;
			word_k_q     <= 3'd0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready)
				dev_count_q <= cfg_data;
			if (do_merge && shadow_we)
				shadow_vld_q[shadow_addr] <= 1'b1;
			if (do_latch) begin
				frame_q  <= 3'd0;
				word_k_q <= 3'd0;
			end else if (out_fire) begin
				if (word_last) begin
					word_k_q <= 3'd0;
					frame_q  <= 3'(frame_q + 3'd1);
				end else begin
					word_k_q <= 3'(word_k_q + 3'd1);
				end
			end
		end
	end

	// command and frame payload, no reset needed
	always_ff @(posedge clk) begin
		if (do_latch) begin
			mode_q  <= lmcce_pkg::mode_t'(mode);
			dev_q   <= device;
			row_q   <= row;
			col_q   <= column;
			flag_q  <= flag;
			value_q <= value;
			rawop_q <= raw_opcode;
		end
		if (do_merge) begin
			op_q   <= new_op;
			data_q <= new_data;
		end
	end

	// shadow row store, registered read
	always_ff @(posedge clk) begin
		if (do_merge && shadow_we)
			shadow_mem[shadow_addr] <= new_data;
		if (do_load) begin
			rd_q     <= shadow_mem[shadow_addr];
			rd_vld_q <= shadow_vld_q[shadow_addr];
		end
	end

endmodule

// ===== rtl/lmcce_checker.sv =====
// port level checks for the led matrix chain command engine
// depends on led_matrix_chain_command_engine_core_defines.svh, bound to the top level
`include "led_matrix_chain_command_engine_core_defines.svh"

module lmcce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] word,
	input logic        frame_end,
	input logic        command_end
);

	// one command at a time: no intake while words go out
	`LMCCE_ASSERT(a_no_overlap, !(in_ready && out_valid), "intake open while sending")

	// the last word of a command always closes a frame
	`LMCCE_ASSERT(a_cmd_end_frame, (out_valid && command_end) |-> frame_end, "command end off frame")

	// sender falls quiet once a command is done
	`LMCCE_ASSERT(a_quiet_after, (out_valid && out_ready && command_end) |=> !out_valid, "word after command end")

	// stalled transaction keeps its payload
	`LMCCE_ASSERT(a_hold, (out_valid && !out_ready) |=> (out_valid && $stable(word) && $stable(frame_end)), "stalled word changed")

	// nothing goes out in reset
	`LMCCE_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "output during reset")

endmodule

bind led_matrix_chain_command_engine_core lmcce_checker u_lmcce_checker (.*);

// ===== verif/tb_led_matrix_chain_command_engine_core.sv =====
// self-checking testbench for led_matrix_chain_command_engine_core
// needs lmcce_pkg and the core rtl; a directed table first, then random phases
// over several chain lengths and idle patterns, checked against typed rows or a shadow-row predictor
`timescale 1ns / 1ps

module tb_led_matrix_chain_command_engine_core;

	// a command sends at most eight frames of eight words
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int NUM_PHASES    = 6;
	localparam int PRINT_CAP     = 40;

	typedef struct packed {
		lmcce_pkg::mode_t mode;
		logic [2:0]       device;
		logic [2:0]       row;
		logic [2:0]       column;
		logic             flag;
		logic [7:0]       value;
		logic [3:0]       raw_opcode;
	} cmd_t;

	typedef struct packed {
		logic [15:0] word;
		logic        frame_end;
		logic        command_end;
	} serial_word_t;

	// one row of the directed table; exp_n < 0 means the predictor decides
	typedef struct {
		cmd_t        cmd;
		int          exp_n;
		logic [15:0] exp_word;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	cmd_t        cur_cmd;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] word;
	logic        frame_end;
	logic        command_end;

	// typed expectation that goes with the command on the bus
	bit          cur_typed;
	int          cur_typed_n;
	logic [15:0] cur_typed_word;

	// predictor state, blank shadow and one chip chain as after reset
	logic [7:0]   row_shadow [64] = '{default: 8'h00};
	logic [3:0]   chain_setting = 4'd1;
	serial_word_t cmd_words [$];
	serial_word_t due_words [$];

	dir_row_t dir_table [$];

	int err_cnt       = 0;
	int cycle_cnt     = 0;
	int cmds_accepted = 0;
	int busy_cmds     = 0;
	int words_checked = 0;
	int cfg_writes    = 0;
	int send_idle_pct;
	int recv_stall_pct;

	led_matrix_chain_command_engine_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (cur_cmd.mode),
		.device      (cur_cmd.device),
		.row         (cur_cmd.row),
		.column      (cur_cmd.column),
		.flag        (cur_cmd.flag),
		.value       (cur_cmd.value),
		.raw_opcode  (cur_cmd.raw_opcode),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.word        (word),
		.frame_end   (frame_end),
		.command_end (command_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// chain length as the block sees it: 0 and anything past the max mean a full chain
	function automatic int chain_length();
		if (chain_setting == 4'd0 || chain_setting > lmcce_pkg::MAX_CHAIN)
			return lmcce_pkg::MAX_CHAIN;
		return int'(chain_setting);
	endfunction

	// one register write: farthest chip first, no-op words for the others
	function automatic void push_frame(input logic [2:0] dev, input logic [7:0] op,
			input logic [7:0] data);
		int len;
		serial_word_t w;
		len = chain_length();
		for (int k = 0; k < len; k++) begin
			w.word        = (len - 1 - k == int'(dev)) ? {op, data} : 16'h0000;
			w.frame_end   = (k == len - 1);
			w.command_end = 1'b0;
			cmd_words.push_back(w);
		end
	endfunction

	// set or clear one pixel in the shadow and send the updated row byte
	function automatic void update_pixel(input logic [2:0] dev, input logic [2:0] r,
			input logic [2:0] col, input logic on);
		logic [5:0] idx;
		logic [7:0] mask;
		idx  = {dev, r};
		mask = lmcce_pkg::LEFT_BIT >> col;
		if (on)
			row_shadow[idx] = row_shadow[idx] | mask;
		else
			row_shadow[idx] = row_shadow[idx] & ~mask;
		push_frame(dev, {5'd0, r} + 8'd1, row_shadow[idx]);
	endfunction

	// fills cmd_words with every serial word one command causes
	function automatic void compute_frames(input cmd_t c);
		cmd_words.delete();
		if (int'(c.device) >= chain_length())
			return;
		case (c.mode)
			lmcce_pkg::MODE_LED: begin
				update_pixel(c.device, c.row, c.column, c.flag);
			end
			lmcce_pkg::MODE_ROW: begin
				row_shadow[{c.device, c.row}] = c.value;
				push_frame(c.device, {5'd0, c.row} + 8'd1, c.value);
			end
			lmcce_pkg::MODE_COLUMN: begin
				for (int r = 0; r < lmcce_pkg::ROWS_PER_DEVICE; r++)
					update_pixel(c.device, 3'(r), c.column, c.value[7 - r]);
			end
			lmcce_pkg::MODE_CLEAR: begin
				for (int r = 0; r < lmcce_pkg::ROWS_PER_DEVICE; r++) begin
					row_shadow[{c.device, 3'(r)}] = 8'h00;
					push_frame(c.device, 8'(r + 1), 8'h00);
				end
			end
			lmcce_pkg::MODE_SHUTDOWN: begin
				push_frame(c.device, {4'd0, lmcce_pkg::REG_SHUTDOWN}, c.flag ? 8'h00 : 8'h01);
			end
			lmcce_pkg::MODE_INTENSITY: begin
				if (c.value <= lmcce_pkg::INTENSITY_MAX)
					push_frame(c.device, {4'd0, lmcce_pkg::REG_INTENSITY}, c.value);
			end
			lmcce_pkg::MODE_SCANLIMIT: begin
				if (c.value <= lmcce_pkg::SCANLIMIT_MAX)
					push_frame(c.device, {4'd0, lmcce_pkg::REG_SCAN_LIMIT}, c.value);
			end
			default: begin
				// raw write goes out as given and leaves the shadow alone
				push_frame(c.device, {4'd0, c.raw_opcode}, c.value);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= PRINT_CAP)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	// everything is sampled at the rising edge; inputs only move at the falling edge
	always @(posedge clk) begin : monitor
		serial_word_t w;
		serial_word_t nxt;
		cycle_cnt++;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				chain_setting = cfg_data;
				cfg_writes++;
			end

			// command transaction: predict first, the block cannot answer in the same cycle
			if (in_valid && in_ready) begin
				compute_frames(cur_cmd);
				cmds_accepted++;
				if (cmd_words.size() > 0)
					busy_cmds++;
				if (cur_typed) begin
					// directed rows run with a one chip chain, so each frame is one word
					for (int i = 0; i < cur_typed_n; i++) begin
						w.word        = cur_typed_word;
						w.frame_end   = 1'b1;
						w.command_end = 1'b1;
						due_words.push_back(w);
					end
				end else begin
					for (int i = 0; i < cmd_words.size(); i++) begin
						w = cmd_words[i];
						w.command_end = (i == cmd_words.size() - 1);
						due_words.push_back(w);
					end
				end
			end

			// serial word transaction
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					report_mismatch($sformatf("word %h fe %b ce %b with nothing expected",
						word, frame_end, command_end));
				end else begin
					nxt = due_words.pop_front();
					words_checked++;
					if (word !== nxt.word)
						report_mismatch($sformatf("word got %h exp %h", word, nxt.word));
					if (frame_end !== nxt.frame_end)
						report_mismatch($sformatf("frame_end got %b exp %b on word %h",
							frame_end, nxt.frame_end, nxt.word));
					if (command_end !== nxt.command_end)
						report_mismatch($sformatf("command_end got %b exp %b on word %h",
							command_end, nxt.command_end, nxt.word));
				end
			end
		end
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycle_cnt, due_words.size());
			$display("led_matrix_chain_command_engine_core test failed");
			$finish;
		end
	end

	// receiver back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		if (!arst_n)
			out_ready = 1'b0;
		else
			out_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	// ---------------------------------------------------------------- stimulus

	task automatic add_row(input lmcce_pkg::mode_t m, input int dev, input int r,
			input int col, input int f, input int v, input int op, input int n,
			input logic [15:0] w);
		dir_row_t d;
		d.cmd.mode       = m;
		d.cmd.device     = 3'(dev);
		d.cmd.row        = 3'(r);
		d.cmd.column     = 3'(col);
		d.cmd.flag       = 1'(f);
		d.cmd.value      = 8'(v);
		d.cmd.raw_opcode = 4'(op);
		d.exp_n          = n;
		d.exp_word       = w;
		dir_table.push_back(d);
	endtask

	// called at a falling edge, returns at a falling edge after the transaction
	task automatic send_command(input cmd_t c, input bit typed, input int n,
			input logic [15:0] w);
		cur_cmd        = c;
		cur_typed      = typed;
		cur_typed_n    = n;
		cur_typed_word = w;
		in_valid       = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			cur_cmd  = cmd_t'({$urandom, $urandom});
			@(negedge clk);
		end
	endtask

	task automatic send_random_command();
		cmd_t c;
		int   len;
		len          = chain_length();
		c            = cmd_t'({$urandom, $urandom});
		c.mode       = lmcce_pkg::mode_t'($urandom_range(7));
		// mostly chips that exist, a few past the end of the chain
		if ($urandom_range(99) < 88)
			c.device = 3'($urandom_range(len - 1));
		// keep intensity and scan limit mostly in range so they produce frames
		if (c.mode == lmcce_pkg::MODE_INTENSITY && $urandom_range(99) < 80)
			c.value = 8'($urandom_range(15));
		if (c.mode == lmcce_pkg::MODE_SCANLIMIT && $urandom_range(99) < 80)
			c.value = 8'($urandom_range(7));
		send_command(c, 1'b0, 0, 16'h0000);
	endtask

	// sender holds off until every predicted word has come back
	task automatic wait_words_done();
		in_valid = 1'b0;
		while (due_words.size() != 0)
			@(negedge clk);
	endtask

	// chain length changes only with the block idle
	task automatic write_chain_length(input logic [3:0] v);
		wait_words_done();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data  = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin : main
		int  target;
		int  halfway;
		bit  paused;
		logic [3:0] cfg_v;

		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = 4'd0;
		in_valid       = 1'b0;
		cur_cmd        = '0;
		cur_typed      = 1'b0;
		cur_typed_n    = 0;
		cur_typed_word = 16'h0000;
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table, chain length 1 from reset, so every frame is a single word
		//       mode                       dev row col f  value op   n  word
		add_row(lmcce_pkg::MODE_LED,        0,  0,  0,  1, 8'h00, 0,  1, 16'h0180); // blank
		add_row(lmcce_pkg::MODE_LED,        0,  0,  0,  0, 8'hFF, 15, 1, 16'h0100);
		add_row(lmcce_pkg::MODE_LED,        0,  7,  7,  1, 8'h00, 0,  1, 16'h0801);
		add_row(lmcce_pkg::MODE_ROW,        0,  7,  5,  0, 8'hFF, 3,  1, 16'h08FF);
		add_row(lmcce_pkg::MODE_ROW,        0,  0,  0,  1, 8'h00, 0,  1, 16'h0100);
		add_row(lmcce_pkg::MODE_LED,        0,  7,  0,  0, 8'h12, 0, -1, 16'h0000);
		add_row(lmcce_pkg::MODE_COLUMN,     0,  3,  0,  0, 8'hA5, 0, -1, 16'h0000);
		add_row(lmcce_pkg::MODE_COLUMN,     0,  0,  7,  1, 8'hFF, 9, -1, 16'h0000);
		add_row(lmcce_pkg::MODE_CLEAR,      0,  6,  2,  1, 8'h77, 5, -1, 16'h0000);
		add_row(lmcce_pkg::MODE_SHUTDOWN,   0,  0,  0,  1, 8'h00, 0,  1, 16'h0C00);
		add_row(lmcce_pkg::MODE_SHUTDOWN,   0,  7,  7,  0, 8'hFF, 15, 1, 16'h0C01);
		add_row(lmcce_pkg::MODE_INTENSITY,  0,  0,  0,  0, 8'h00, 0,  1, 16'h0A00);
		add_row(lmcce_pkg::MODE_INTENSITY,  0,  0,  0,  0, 8'h0F, 0,  1, 16'h0A0F);
		add_row(lmcce_pkg::MODE_INTENSITY,  0,  0,  0,  0, 8'h10, 0,  0, 16'h0000); // past max
		add_row(lmcce_pkg::MODE_INTENSITY,  0,  0,  0,  1, 8'hFF, 0,  0, 16'h0000);
		add_row(lmcce_pkg::MODE_SCANLIMIT,  0,  0,  0,  0, 8'h07, 0,  1, 16'h0B07);
		add_row(lmcce_pkg::MODE_SCANLIMIT,  0,  0,  0,  0, 8'h00, 0,  1, 16'h0B00);
		add_row(lmcce_pkg::MODE_SCANLIMIT,  0,  0,  0,  0, 8'h08, 0,  0, 16'h0000); // past max
		add_row(lmcce_pkg::MODE_RAW,        0,  0,  0,  0, 8'hFF, 15, 1, 16'h0FFF);
		add_row(lmcce_pkg::MODE_RAW,        0,  0,  0,  0, 8'h00, 0,  1, 16'h0000);
		add_row(lmcce_pkg::MODE_RAW,        0,  0,  0,  0, 8'h3C, 1,  1, 16'h013C); // no shadow
		add_row(lmcce_pkg::MODE_LED,        0,  0,  3,  1, 8'h00, 0, -1, 16'h0000);
		add_row(lmcce_pkg::MODE_ROW,        7,  2,  0,  0, 8'hAA, 0,  0, 16'h0000); // off chain
		add_row(lmcce_pkg::MODE_SHUTDOWN,   1,  0,  0,  1, 8'h00, 0,  0, 16'h0000);
		add_row(lmcce_pkg::MODE_COLUMN,     0,  0,  3,  0, 8'h00, 0, -1, 16'h0000);

		foreach (dir_table[i])
			send_command(dir_table[i].cmd, dir_table[i].exp_n >= 0,
				dir_table[i].exp_n, dir_table[i].exp_word);

		// random phases: chain length extremes and idle patterns change per phase
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin cfg_v = 4'd8;  send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin cfg_v = 4'd0;  send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin cfg_v = 4'd3;  send_idle_pct = 0;  recv_stall_pct = 54; end
				3: begin cfg_v = 4'd15; send_idle_pct = 10; recv_stall_pct = 10; end
				4: begin cfg_v = 4'd1;  send_idle_pct = 54; recv_stall_pct = 0;  end
				default: begin
					cfg_v = 4'($urandom_range(2, 7));
					send_idle_pct  = 10;
					recv_stall_pct = 54;
				end
			endcase
			write_chain_length(cfg_v);
			target  = busy_cmds + ITEMS_PER_PHASE;
			halfway = busy_cmds + ITEMS_PER_PHASE / 2;
			paused  = 1'b0;
			while (busy_cmds < target) begin
				if (!paused && busy_cmds >= halfway) begin
					// let the block drain completely mid-phase
					wait_words_done();
					paused = 1'b1;
				end
				send_random_command();
			end
		end

		wait_words_done();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (due_words.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", due_words.size()));

		$display("ran %0d commands (%0d with output) over %0d chain length writes",
			cmds_accepted, busy_cmds, cfg_writes);
		$display("checked %0d serial words in %0d cycles, %0d mismatches",
			words_checked, cycle_cnt, err_cnt);
		if (err_cnt == 0)
			$display("led_matrix_chain_command_engine_core test passed");
		else
			$display("led_matrix_chain_command_engine_core test failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lmcce_pkg.sv
rtl/led_matrix_chain_command_engine_core.sv
rtl/lmcce_checker.sv
verif/tb_led_matrix_chain_command_engine_core.sv
